>>> rtl/core/qte_pkg.sv
`default_nettype none

package qte_pkg;

    // Default port widths
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF     = 16;

    // Internal fixed point: components at Q1.29, products at scale 2^58
    localparam int ALIGN_W    = 30;
    localparam int ALIGN_FRAC = 29;
    localparam int PROD_W     = 60;
    localparam int WIDE_W     = 64;

    localparam logic signed [WIDE_W-1:0] PROD_ONE = 64'sh0400_0000_0000_0000;
    localparam logic [WIDE_W-1:0]        SQRT_ONE = 64'h1000_0000_0000_0000;

    // Shift that brings the pitch sine term from scale 2^58 to scale 2^30
    localparam int PITCH_SHIFT = 28;

    localparam int SQRT_STEPS    = 31;
    localparam int CORDIC_STAGES = 31;
    localparam int TURN_W        = 32;

    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32
    localparam logic [TURN_W-1:0] ATAN_TURN [0:CORDIC_STAGES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1
    };

    // Quadratic forms handed from the front end to the square root
    typedef struct packed {
        logic signed [WIDE_W-1:0] sin_roll;
        logic signed [WIDE_W-1:0] cos_roll;
        logic signed [WIDE_W-1:0] sin_yaw;
        logic signed [WIDE_W-1:0] cos_yaw;
        logic signed [WIDE_W-1:0] sin_pitch;
        logic                     sat;
        logic                     pitch_pos;
    } qte_forms_t;

    // Flags that travel with the roll arctangent
    typedef struct packed {
        logic sat;
        logic pitch_pos;
    } qte_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/quaternion_to_euler_angles.sv
`default_nettype none

// Channel  | Direction | Ports                                           | Handshake
// ---------+-----------+-------------------------------------------------+-----------------
// s_       | in        | s_quat_w, s_quat_x, s_quat_y, s_quat_z          | s_valid/s_ready
// m_       | out       | m_roll_angle, m_pitch_angle, m_yaw_angle,       | m_valid/m_ready
//          |           | m_pitch_saturated                               |
//
// One request enters per cycle while the pipe is not stalled; each passes from acceptance to m_valid through
// 5 front-end stages, 31 square-root stages, 32 CORDIC stages and 1 output register.
// The 31-step square root for the pitch cosine sets the depth ahead of the arctangents.
// aresetn (synchronous, active low) clears every valid bit; data registers are not reset.
// The whole pipe advances together: it holds while m_valid is high and m_ready is low,
// and s_ready follows that same enable, so a stall neither drops nor repeats a request.

module quaternion_to_euler_angles #(
    parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF,
    parameter int ANGLE_BITS     = qte_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [COMPONENT_BITS-1:0]  s_quat_w,
    input  wire logic signed [COMPONENT_BITS-1:0]  s_quat_x,
    input  wire logic signed [COMPONENT_BITS-1:0]  s_quat_y,
    input  wire logic signed [COMPONENT_BITS-1:0]  s_quat_z,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [ANGLE_BITS-1:0]           m_roll_angle,
    output logic signed [ANGLE_BITS-1:0]           m_pitch_angle,
    output logic signed [ANGLE_BITS-1:0]           m_yaw_angle,
    output logic                                   m_pitch_saturated
);

    localparam int WW     = qte_pkg::WIDE_W;
    localparam int TW     = qte_pkg::TURN_W;
    localparam int FORM_W = $bits(qte_pkg::qte_forms_t);
    localparam int FLAG_W = $bits(qte_pkg::qte_flags_t);

    // Global advance: move when the output register is empty or being taken
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic signed [COMPONENT_BITS-1:0] comp [0:3];
    assign comp[0] = s_quat_w;
    assign comp[1] = s_quat_x;
    assign comp[2] = s_quat_y;
    assign comp[3] = s_quat_z;

    // Front end: align, multiply, sum, square the pitch sine, form the radicand
    logic                 quad_valid;
    qte_pkg::qte_forms_t  quad_forms;
    logic [WW-1:0]        quad_rad;

    qte_quad #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_comp   (comp),
        .out_valid (quad_valid),
        .out_forms (quad_forms),
        .out_rad   (quad_rad)
    );

    // Pitch cosine = sqrt(1 - s^2) at scale 2^30; the forms ride alongside
    logic                sq_valid;
    logic [WW-1:0]       sq_root;
    logic [FORM_W-1:0]   sq_side;
    qte_pkg::qte_forms_t sq_forms;

    qte_sqrt #(
        .SIDE_W (FORM_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (quad_valid),
        .in_rad    (quad_rad),
        .in_side   (quad_forms),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_forms = qte_pkg::qte_forms_t'(sq_side);

    qte_pkg::qte_flags_t flags_in, flags_out;
    logic [FLAG_W-1:0]   flags_raw;
    assign flags_in.sat       = sq_forms.sat;
    assign flags_in.pitch_pos = sq_forms.pitch_pos;
    assign flags_out          = qte_pkg::qte_flags_t'(flags_raw);

    // Three arctangent pipelines in lockstep; roll carries valid and flags
    logic          cr_valid;
    logic [TW-1:0] roll_turn, pitch_turn, yaw_turn;

    qte_cordic #(
        .SIDE_W (FLAG_W)
    ) u_cordic_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_y      (sq_forms.sin_roll),
        .in_x      (sq_forms.cos_roll),
        .in_side   (flags_in),
        .out_valid (cr_valid),
        .out_angle (roll_turn),
        .out_side  (flags_raw)
    );

    qte_cordic #(
        .SIDE_W (1)
    ) u_cordic_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_y      (sq_forms.sin_pitch),
        .in_x      (signed'(sq_root)),
        .in_side   (1'b0),
        .out_valid (),
        .out_angle (pitch_turn),
        .out_side  ()
    );

    qte_cordic #(
        .SIDE_W (1)
    ) u_cordic_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_y      (sq_forms.sin_yaw),
        .in_x      (sq_forms.cos_yaw),
        .in_side   (1'b0),
        .out_valid (),
        .out_angle (yaw_turn),
        .out_side  ()
    );

    // Round the 32-bit turn fraction to the port width and wrap
    logic [ANGLE_BITS-1:0] roll_next, pitch_cordic, yaw_next, pitch_next;

    if (ANGLE_BITS >= TW) begin : g_full
        assign roll_next    = ANGLE_BITS'(roll_turn);
        assign pitch_cordic = ANGLE_BITS'(pitch_turn);
        assign yaw_next     = ANGLE_BITS'(yaw_turn);
    end else begin : g_round
        localparam logic [TW:0] HALF_LSB = (TW+1)'(1) << (TW - 1 - ANGLE_BITS);
        logic [TW:0] roll_sum, pitch_sum, yaw_sum;
        assign roll_sum     = {1'b0, roll_turn}  + HALF_LSB;
        assign pitch_sum    = {1'b0, pitch_turn} + HALF_LSB;
        assign yaw_sum      = {1'b0, yaw_turn}   + HALF_LSB;
        assign roll_next    = roll_sum[TW-ANGLE_BITS +: ANGLE_BITS];
        assign pitch_cordic = pitch_sum[TW-ANGLE_BITS +: ANGLE_BITS];
        assign yaw_next     = yaw_sum[TW-ANGLE_BITS +: ANGLE_BITS];
    end

    // Gimbal lock: a quarter turn carrying the sign of the sine term
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    always_comb begin
        if (!flags_out.sat) begin
            pitch_next = pitch_cordic;
        end else if (flags_out.pitch_pos) begin
            pitch_next = QUARTER;
        end else begin
            pitch_next = -QUARTER;
        end
    end

    // Output register
    logic                  m_valid_reg;
    logic [ANGLE_BITS-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                  sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            sat_reg   <= flags_out.sat;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_roll_angle      = signed'(roll_reg);
    assign m_pitch_angle     = signed'(pitch_reg);
    assign m_yaw_angle       = signed'(yaw_reg);
    assign m_pitch_saturated = sat_reg;

endmodule

`default_nettype wire

>>> rtl/core/qte_quad.sv
`default_nettype none

module qte_quad #(
    parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [COMPONENT_BITS-1:0]  in_comp [0:3],
    output logic                                   out_valid,
    output qte_pkg::qte_forms_t                    out_forms,
    output logic [qte_pkg::WIDE_W-1:0]             out_rad
);

    localparam int AW = qte_pkg::ALIGN_W;
    localparam int PW = qte_pkg::PROD_W;
    localparam int WW = qte_pkg::WIDE_W;

    // Stage 0: aligned components
    logic signed [AW-1:0] comp_next [0:3];
    logic signed [AW-1:0] comp_reg  [0:3];
    logic                 v0_reg;

    for (genvar k = 0; k < 4; k++) begin : g_align
        if (COMPONENT_BITS - 1 < qte_pkg::ALIGN_FRAC) begin : g_up
            assign comp_next[k] = AW'(in_comp[k]) <<< (qte_pkg::ALIGN_FRAC - (COMPONENT_BITS - 1));
        end else if (COMPONENT_BITS - 1 > qte_pkg::ALIGN_FRAC) begin : g_down
            assign comp_next[k] = AW'(in_comp[k] >>> ((COMPONENT_BITS - 1) - qte_pkg::ALIGN_FRAC));
        end else begin : g_same
            assign comp_next[k] = in_comp[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            comp_reg <= comp_next;
        end
    end

    // Stage 1: products (w, x, y, z at indices 0..3)
    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;
    logic                 v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg <= comp_reg[0] * comp_reg[1];
            yz_reg <= comp_reg[2] * comp_reg[3];
            xx_reg <= comp_reg[1] * comp_reg[1];
            yy_reg <= comp_reg[2] * comp_reg[2];
            wy_reg <= comp_reg[0] * comp_reg[2];
            zx_reg <= comp_reg[3] * comp_reg[1];
            wz_reg <= comp_reg[0] * comp_reg[3];
            xy_reg <= comp_reg[1] * comp_reg[2];
            zz_reg <= comp_reg[3] * comp_reg[3];
        end
    end

    // Stage 2: quadratic forms
    qte_pkg::qte_forms_t forms_next, f2_reg;
    logic                v2_reg;

    always_comb begin
        forms_next.sin_roll  = (WW'(wx_reg) + WW'(yz_reg)) <<< 1;
        forms_next.cos_roll  = qte_pkg::PROD_ONE - ((WW'(xx_reg) + WW'(yy_reg)) <<< 1);
        forms_next.sin_yaw   = (WW'(wz_reg) + WW'(xy_reg)) <<< 1;
        forms_next.cos_yaw   = qte_pkg::PROD_ONE - ((WW'(yy_reg) + WW'(zz_reg)) <<< 1);
        forms_next.sin_pitch = (WW'(wy_reg) - WW'(zx_reg)) <<< 1;
        forms_next.sat       = (forms_next.sin_pitch >= qte_pkg::PROD_ONE) ||
                               (forms_next.sin_pitch <= -qte_pkg::PROD_ONE);
        forms_next.pitch_pos = (forms_next.sin_pitch > 0);
        // bring the pitch term to scale 2^30, floor
        forms_next.sin_pitch = forms_next.sin_pitch >>> qte_pkg::PITCH_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_reg <= forms_next;
        end
    end

    // Stage 3: square of the pitch sine
    logic signed [31:0]    s32;
    logic signed [WW-1:0]  sq_reg;
    qte_pkg::qte_forms_t   f3_reg;
    logic                  v3_reg;

    assign s32 = f2_reg.sin_pitch[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= s32 * s32;
            f3_reg <= f2_reg;
        end
    end

    // Stage 4: radicand for the cosine
    logic [WW-1:0]       rad_reg;
    qte_pkg::qte_forms_t f4_reg;
    logic                v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= qte_pkg::SQRT_ONE - sq_reg;
            f4_reg  <= f3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_forms = f4_reg;
    assign out_rad   = rad_reg;

endmodule

`default_nettype wire

>>> rtl/core/qte_sqrt.sv
`default_nettype none

module qte_sqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [qte_pkg::WIDE_W-1:0]     in_rad,
    input  wire logic [SIDE_W-1:0]              in_side,
    output logic                                out_valid,
    output logic [qte_pkg::WIDE_W-1:0]          out_root,
    output logic [SIDE_W-1:0]                   out_side
);

    localparam int N  = qte_pkg::SQRT_STEPS;
    localparam int WW = qte_pkg::WIDE_W;

    logic [WW-1:0]     rem_reg  [0:N];
    logic [WW-1:0]     root_reg [0:N];
    logic [SIDE_W-1:0] side_reg [0:N];
    logic              v_reg    [0:N];

    always_comb begin
        rem_reg[0]  = in_rad;
        root_reg[0] = '0;
        side_reg[0] = in_side;
        v_reg[0]    = in_valid;
    end

    // One result bit per stage, trial bit 4^(N-1-k)
    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [WW-1:0] TRIAL = WW'(1) << (2 * (N - 1 - k));
        logic [WW-1:0] cand;
        assign cand = root_reg[k] + TRIAL;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_reg[k];
                if (rem_reg[k] >= cand) begin
                    rem_reg[k+1]  <= rem_reg[k] - cand;
                    root_reg[k+1] <= (root_reg[k] >> 1) + TRIAL;
                end else begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_root  = root_reg[N];
    assign out_side  = side_reg[N];

endmodule

`default_nettype wire

>>> rtl/core/qte_cordic.sv
`default_nettype none

module qte_cordic #(
    parameter int SIDE_W = 1
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [qte_pkg::WIDE_W-1:0]   in_y,
    input  wire logic signed [qte_pkg::WIDE_W-1:0]   in_x,
    input  wire logic [SIDE_W-1:0]                   in_side,
    output logic                                     out_valid,
    output logic [qte_pkg::TURN_W-1:0]               out_angle,
    output logic [SIDE_W-1:0]                        out_side
);

    localparam int N  = qte_pkg::CORDIC_STAGES;
    localparam int WW = qte_pkg::WIDE_W;
    localparam int TW = qte_pkg::TURN_W;

    logic signed [WW-1:0] x_reg    [0:N];
    logic signed [WW-1:0] y_reg    [0:N];
    logic [TW-1:0]        a_reg    [0:N];
    logic                 zero_reg [0:N];
    logic [SIDE_W-1:0]    side_reg [0:N];
    logic                 v_reg    [0:N];

    // Pre-rotation: turn a left half-plane vector by a half turn
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (in_x == 0) && (in_y == 0);
            side_reg[0] <= in_side;
            if (in_x < 0) begin
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
                a_reg[0] <= qte_pkg::HALF_TURN;
            end else begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [WW-1:0] x_sh, y_sh;
        assign x_sh = x_reg[i] >>> i;
        assign y_sh = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
                if (!y_reg[i][WW-1]) begin
                    x_reg[i+1] <= x_reg[i] + y_sh;
                    y_reg[i+1] <= y_reg[i] - x_sh;
                    a_reg[i+1] <= a_reg[i] + qte_pkg::ATAN_TURN[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - y_sh;
                    y_reg[i+1] <= y_reg[i] + x_sh;
                    a_reg[i+1] <= a_reg[i] - qte_pkg::ATAN_TURN[i];
                end
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_angle = zero_reg[N] ? '0 : a_reg[N];
    assign out_side  = side_reg[N];

endmodule

`default_nettype wire

>>> test/tb_quaternion_to_euler_angles.sv
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles;

    localparam int CW = 16;
    localparam int AW = 16;
    // Pipe depth from acceptance to m_valid; the tail wait adds a margin to it
    localparam int PIPE_DEPTH = 69;

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] yaw;
        logic                 sat;
    } euler_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_quat_w = '0;
    logic signed [CW-1:0] s_quat_x = '0;
    logic signed [CW-1:0] s_quat_y = '0;
    logic signed [CW-1:0] s_quat_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [AW-1:0] m_roll_angle;
    logic signed [AW-1:0] m_pitch_angle;
    logic signed [AW-1:0] m_yaw_angle;
    logic m_pitch_saturated;

    euler_t angles_due[$];
    int     mismatches = 0;
    bit     calm = 1'b0;       // no idling on either side while set

    quaternion_to_euler_angles dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x),
        .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_roll_angle(m_roll_angle), .m_pitch_angle(m_pitch_angle),
        .m_yaw_angle(m_yaw_angle), .m_pitch_saturated(m_pitch_saturated)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Floor shift on signed 64-bit values; >>> already floors
    function automatic logic signed [63:0] fshr(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    // Vectoring arctangent, result as a 32-bit turn fraction
    function automatic logic [31:0] turn_atan2(logic signed [63:0] y, logic signed [63:0] x);
        logic [31:0] ang;
        logic signed [63:0] xs, ys;
        ang = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = qte_pkg::HALF_TURN;
        end
        for (int i = 0; i < qte_pkg::CORDIC_STAGES; i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                ang = ang + qte_pkg::ATAN_TURN[i];
            end else begin
                x = x - ys;
                y = y + xs;
                ang = ang - qte_pkg::ATAN_TURN[i];
            end
        end
        return ang;
    endfunction

    // Round the turn fraction to the output width, wrapping
    function automatic logic [AW-1:0] round_turn(logic [31:0] ang);
        logic [32:0] a;
        a = {1'b0, ang} + (33'd1 << (31 - AW));
        return a[32-AW +: AW];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] t);
        logic [63:0] res, b;
        res = '0;
        b = 64'd1 << 62;
        while (b > t) b = b >> 2;
        while (b != 0) begin
            if (t >= res + b) begin
                t = t - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic euler_t predict_euler(logic signed [CW-1:0] qw, logic signed [CW-1:0] qx,
                                             logic signed [CW-1:0] qy, logic signed [CW-1:0] qz);
        logic signed [63:0] w, x, y, z, sr, cr, sp, sy, cy, s30;
        logic signed [63:0] one;
        logic [63:0] c30;
        euler_t e;
        one = 64'sd1 <<< 58;
        // align Q1.15 to Q1.29
        w = 64'(qw) <<< 14;
        x = 64'(qx) <<< 14;
        y = 64'(qy) <<< 14;
        z = 64'(qz) <<< 14;
        sr = 2 * (w * x + y * z);
        cr = one - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = one - 2 * (y * y + z * z);
        if (sp >= one || sp <= -one) begin
            // gimbal lock: quarter turn with the sign of the term
            e.pitch = (sp > 0) ? (AW'(1) << (AW - 2)) : -(AW'(1) << (AW - 2));
            e.sat = 1'b1;
        end else begin
            s30 = fshr(sp, qte_pkg::PITCH_SHIFT);
            c30 = int_sqrt((64'd1 << 60) - 64'(s30 * s30));
            e.pitch = round_turn(turn_atan2(s30, c30));
            e.sat = 1'b0;
        end
        e.roll = round_turn(turn_atan2(sr, cr));
        e.yaw = round_turn(turn_atan2(sy, cy));
        return e;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 8);
    endfunction

    // Send one request; hold valid and payload until accepted
    task automatic send_quat(logic signed [CW-1:0] qw, logic signed [CW-1:0] qx,
                             logic signed [CW-1:0] qy, logic signed [CW-1:0] qz);
        while (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_quat_w <= qw;
        s_quat_x <= qx;
        s_quat_y <= qy;
        s_quat_z <= qz;
        angles_due.push_back(predict_euler(qw, qx, qy, qz));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // leave valid high; the next send or idle decides whether to drop it
    endtask

    task automatic park_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: random back-pressure, compare every accepted result
    initial begin
        euler_t want;
        @(posedge aclk);
        forever begin
            m_ready <= !idle_now();
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (angles_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result roll=%0d pitch=%0d yaw=%0d sat=%0b",
                                 m_roll_angle, m_pitch_angle, m_yaw_angle, m_pitch_saturated);
                end else begin
                    want = angles_due.pop_front();
                    if (m_roll_angle !== want.roll || m_pitch_angle !== want.pitch ||
                        m_yaw_angle !== want.yaw || m_pitch_saturated !== want.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp r=%0d p=%0d y=%0d s=%0b got r=%0d p=%0d y=%0d s=%0b",
                                     want.roll, want.pitch, want.yaw, want.sat,
                                     m_roll_angle, m_pitch_angle, m_yaw_angle,
                                     m_pitch_saturated);
                    end
                end
            end
        end
    end

    // Directed corners: extremes, zero vector, half turn, near gimbal lock both ways
    task automatic test_corners();
        logic signed [CW-1:0] ext [4];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
        send_quat(16'sh7fff, 0, 0, 0);          // identity
        send_quat(0, 0, 0, 0);                  // zero quaternion
        send_quat(0, 16'sh7fff, 0, 0);          // roll half turn
        send_quat(0, 0, 0, 16'sh7fff);          // yaw half turn
        send_quat(16'sh5a82, 0, 16'sh5a82, 0);  // pitch up, just short of lock
        send_quat(16'sh5a82, 0, 16'sha57e, 0);  // pitch down, just short of lock
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sh8000, 0, 16'sh7fff, 0);  // non-unit, saturated
        send_quat(16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000);
        for (int i = 0; i < 12; i++)
            send_quat(ext[$urandom_range(3)], ext[$urandom_range(3)],
                      ext[$urandom_range(3)], ext[$urandom_range(3)]);
        park_sender();
    endtask

    // Wait with the sender parked until every pending result has arrived
    task automatic drain_results();
        park_sender();
        while (angles_due.size() != 0) @(posedge aclk);
    endtask

    // Random quaternions: mostly small components with norm at most one, some raw noise
    task automatic test_random(int count);
        logic signed [CW-1:0] c [4];
        int scale;
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 3) && (n < count / 3 + 150);
            if ($urandom_range(3) == 0) begin
                foreach (c[k]) c[k] = 16'($urandom());
            end else begin
                // small components keep the norm near or below one
                scale = $urandom_range(4) + 11;
                foreach (c[k]) c[k] = $signed(16'($urandom() >> (32 - scale)))
                                      - (16'sd1 <<< (scale - 1));
            end
            send_quat(c[0], c[1], c[2], c[3]);
            if (n == count / 2) drain_results();
        end
        calm = 1'b0;
        park_sender();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corners();
        drain_results();
        test_random(1030);
        while (angles_due.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 20) @(posedge aclk);
        if (mismatches == 0 && angles_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
